// ----- src/lowest_linger_path_select_defines.svh -----
// Assertion macros used by the checker file of lowest_linger_path_select.
// No dependencies; the enclosing module must have clk and rst_n.
`ifndef LOWEST_LINGER_PATH_SELECT_DEFINES_SVH
`define LOWEST_LINGER_PATH_SELECT_DEFINES_SVH

// same-cycle implication, off during reset
`define LLS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define LLS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/lls_pkg.sv -----
// Shared constants and types for lowest_linger_path_select.
// No dependencies.
package lls_pkg;

  localparam int DEF_SLOTS = 8;

  localparam logic [15:0] RST_BURST_LIMIT      = 16'd65428;
  localparam logic [15:0] RST_DEFAULT_INTERVAL = 16'd50;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_BURST_LIMIT      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_INTERVAL = 1'b1;

  // shared divider: 64-bit dividend, 32-bit divisor, one quotient bit per cycle
  localparam int DIV_N     = 64;
  localparam int DIV_D     = 32;
  localparam int DIV_CNT_W = $clog2(DIV_N);

  typedef struct packed {
    logic        mem_free;
    logic [31:0] rate;
    logic [30:0] queued;
  } lls_slot_t;

endpackage

// ----- src/lls_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Depends on lls_pkg.
module lls_div import lls_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start_i,
  input  logic [DIV_N-1:0] dividend_i,
  input  logic [DIV_D-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_N-1:0] quotient_o
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_N-1:0]     quo_r;
  logic [DIV_D-1:0]     rem_r;
  logic [DIV_D-1:0]     dvs_r;

  logic [DIV_D:0] rem_sh;
  logic           ge;
  logic [DIV_D:0] diff;

  assign rem_sh = {rem_r, quo_r[DIV_N-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};
  assign diff   = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        quo_r  <= dividend_i;
        rem_r  <= '0;
        dvs_r  <= divisor_i;
      end else if (busy_r) begin
        // remainder stays below the divisor, so it fits DIV_D bits
        rem_r <= ge ? diff[DIV_D-1:0] : rem_sh[DIV_D-1:0];
        quo_r <= {quo_r[DIV_N-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_N - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_r;
  assign quotient_o = quo_r;

endmodule

// ----- src/lowest_linger_path_select.sv -----
// lowest_linger_path_select: picks the path (slot) with the lowest linger time.
// Input channel (in_valid / in_stall): mode 0 is a path report that fills the
// next slot; reports past the last slot are dropped. Mode 1 is a decide, which
// yields exactly one result on the output channel (out_valid / out_stall) and
// starts a new round. Config port: cfg_we with cfg_idx selects burst_limit (0)
// or default_interval (1); write only while the block is idle.
// Flow: one item at a time; in_stall is high while it works.
//   report: ST_RPT_RD, then the shared divider when a linger is computed;
//   idle after ST_RPT_RD if the pace is zero; dropped reports stay idle.
//   decide: ST_DEC_RD, then ST_EMIT when failed or burst is zero, otherwise
//   ST_DEC_MUL, the shared divider and ST_EMIT.
// Per-slot data and pacing averages sit in two small synchronous RAMs with
// registered reads; pacing averages carry per-slot valid bits so reset
// clears them at once, with no clearing pass.
// Result sits in an output register; while out_stall holds it, reports are
// still taken, and a following decide waits at its final step.
// Reset (rst_n low, synchronous) restores both registers, clears the round
// and zeroes all pacing averages.
module lowest_linger_path_select import lls_pkg::*; #(
  parameter int SLOTS = DEF_SLOTS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_mode,
  input  logic [31:0]          in_socket_pacing_rate,
  input  logic [30:0]          in_queued_bytes,
  input  logic [30:0]          in_path_timeout,
  input  logic                 in_memory_free,
  input  logic [63:0]          in_window_end,
  input  logic [63:0]          in_send_next,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_selected_slot,
  output logic                 out_failed,
  output logic [30:0]          out_timer_interval,
  output logic [15:0]          out_burst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [15:0]          cfg_wdata
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_RPT_RD, ST_DEC_RD, ST_DEC_MUL, ST_DIV, ST_EMIT
  } state_t;

  state_t state_r;

  logic [15:0] burst_limit_r;
  logic [15:0] default_interval_r;

  // round state
  logic [CNT_W-1:0]  count_r;
  logic [63:0]       best_linger_r;
  logic [SLOT_W-1:0] best_slot_r;
  logic [30:0]       max_timeout_r;

  // per-item working registers
  logic              op_dec_r;
  logic [SLOT_W-1:0] slot_r;
  logic [30:0]       q_r;
  logic [31:0]       rate_r;
  logic              failed_r;
  logic [30:0]       interval_r;
  logic [63:0]       room_r;
  logic [15:0]       burst_r;
  logic [62:0]       prod_a_r;
  logic [47:0]       prod_b_r;
  logic [31:0]       den_r;

  // divider hookup
  logic              div_start_r;
  logic [63:0]       div_dividend_r;
  logic [31:0]       div_divisor_r;
  logic              div_done;
  logic [63:0]       div_quo;

  // output register
  logic              out_valid_r;
  logic [2:0]        out_slot_r;
  logic              out_failed_r;
  logic [30:0]       out_interval_r;
  logic [15:0]       out_burst_r;

  // memories
  lls_slot_t         slot_mem [SLOTS];
  lls_slot_t         sm_rdata_r;
  logic [31:0]       pace_mem [SLOTS];
  logic [31:0]       pm_rdata_r;
  logic [SLOTS-1:0]  pv_r;

  logic              in_xfer;
  logic              out_free;
  logic [SLOT_W-1:0] cnt_slot;
  logic [SLOT_W-1:0] pm_raddr;
  logic              pm_we;
  logic [SLOT_W-1:0] pm_waddr;
  logic [31:0]       pm_wdata;
  logic [31:0]       avg_eff;
  logic              dec_fail;
  logic [15:0]       dec_burst;

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign cnt_slot = count_r[SLOT_W-1:0];
  assign pm_raddr = in_mode ? best_slot_r : cnt_slot;
  assign avg_eff  = pv_r[slot_r] ? pm_rdata_r : 32'd0;

  // decide: fail on empty round or missing memory; negative window clamps to 0
  assign dec_fail  = failed_r || !sm_rdata_r.mem_free;
  assign dec_burst = dec_fail ? 16'd0 :
                     room_r[63] ? 16'd0 :
                     (room_r < {48'd0, burst_limit_r}) ? room_r[15:0] : burst_limit_r;

  always_comb begin
    pm_we    = 1'b0;
    pm_waddr = slot_r;
    pm_wdata = rate_r;
    case (state_r)
      ST_RPT_RD: begin
        // seed an empty average from the socket rate
        pm_we    = (avg_eff == 32'd0);
        pm_wdata = rate_r;
      end
      ST_DIV: begin
        pm_we    = div_done && op_dec_r;
        pm_wdata = div_quo[31:0];
      end
      default: begin
        pm_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_xfer && !in_mode && (count_r != CNT_W'(SLOTS))) begin
      slot_mem[cnt_slot] <= '{mem_free: in_memory_free,
                              rate:     in_socket_pacing_rate,
                              queued:   in_queued_bytes};
    end
    sm_rdata_r <= slot_mem[best_slot_r];
  end

  always_ff @(posedge clk) begin
    if (pm_we) begin
      pace_mem[pm_waddr] <= pm_wdata;
    end
    pm_rdata_r <= pace_mem[pm_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
    end else if (pm_we) begin
      pv_r[pm_waddr] <= 1'b1;
    end
  end

  lls_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (div_start_r),
    .dividend_i (div_dividend_r),
    .divisor_i  (div_divisor_r),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= ST_IDLE;
      burst_limit_r      <= RST_BURST_LIMIT;
      default_interval_r <= RST_DEFAULT_INTERVAL;
      count_r            <= '0;
      best_linger_r      <= '1;
      best_slot_r        <= '0;
      max_timeout_r      <= '0;
      div_start_r        <= 1'b0;
      out_valid_r        <= 1'b0;
      op_dec_r           <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_idx)
          CFG_BURST_LIMIT:      burst_limit_r      <= cfg_wdata;
          CFG_DEFAULT_INTERVAL: default_interval_r <= cfg_wdata;
          default: ;
        endcase
      end

      case (state_r)
        ST_IDLE: begin
          if (in_xfer && !in_mode) begin
            if (count_r != CNT_W'(SLOTS)) begin
              op_dec_r <= 1'b0;
              slot_r   <= cnt_slot;
              q_r      <= in_queued_bytes;
              rate_r   <= in_socket_pacing_rate;
              count_r  <= count_r + 1'b1;
              if (in_path_timeout > max_timeout_r) begin
                max_timeout_r <= in_path_timeout;
              end
              state_r <= ST_RPT_RD;
            end
          end else if (in_xfer) begin
            op_dec_r   <= 1'b1;
            slot_r     <= best_slot_r;
            interval_r <= (max_timeout_r != 31'd0) ? max_timeout_r
                                                    : {15'd0, default_interval_r};
            failed_r   <= (count_r == '0) || (CNT_W'(best_slot_r) >= count_r);
            room_r     <= in_window_end - in_send_next;
            // new round; pacing averages carry over
            count_r       <= '0;
            best_linger_r <= '1;
            best_slot_r   <= '0;
            max_timeout_r <= '0;
            state_r       <= ST_DEC_RD;
          end
        end

        ST_RPT_RD: begin
          if (avg_eff == 32'd0 && rate_r == 32'd0) begin
            state_r <= ST_IDLE;
          end else begin
            div_start_r    <= 1'b1;
            div_dividend_r <= {1'b0, q_r, 32'd0};
            div_divisor_r  <= (avg_eff == 32'd0) ? rate_r : avg_eff;
            state_r        <= ST_DIV;
          end
        end

        ST_DEC_RD: begin
          failed_r <= dec_fail;
          burst_r  <= dec_burst;
          prod_a_r <= 63'(avg_eff) * 63'(sm_rdata_r.queued);
          prod_b_r <= 48'(sm_rdata_r.rate) * 48'(dec_burst);
          den_r    <= 32'(dec_burst) + 32'(sm_rdata_r.queued);
          if (dec_burst == 16'd0) begin
            state_r <= ST_EMIT;
          end else begin
            state_r <= ST_DEC_MUL;
          end
        end

        ST_DEC_MUL: begin
          div_start_r    <= 1'b1;
          div_dividend_r <= 64'(prod_a_r) + 64'(prod_b_r);
          div_divisor_r  <= den_r;
          state_r        <= ST_DIV;
        end

        ST_DIV: begin
          if (div_done) begin
            if (op_dec_r) begin
              state_r <= ST_EMIT;
            end else begin
              // strict minimum, zero linger never wins
              if (div_quo != 64'd0 && div_quo < best_linger_r) begin
                best_linger_r <= div_quo;
                best_slot_r   <= slot_r;
              end
              state_r <= ST_IDLE;
            end
          end
        end

        ST_EMIT: begin
          if (out_free) begin
            out_valid_r    <= 1'b1;
            out_slot_r     <= 3'(slot_r);
            out_failed_r   <= failed_r;
            out_interval_r <= interval_r;
            out_burst_r    <= burst_r;
            state_r        <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_selected_slot  = out_slot_r;
  assign out_failed         = out_failed_r;
  assign out_timer_interval = out_interval_r;
  assign out_burst          = out_burst_r;

endmodule

// ----- src/lls_checker.sv -----
// Port-level checks for lowest_linger_path_select, bound to the top level.
// Depends on lls_pkg-free ports only and lowest_linger_path_select_defines.svh.
`include "lowest_linger_path_select_defines.svh"

module lls_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_mode,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_failed,
  input logic [15:0] out_burst
);

  `LLS_ASSERT_IMP(a_fail_no_burst, out_valid && out_failed, out_burst == 16'd0, "burst on failed result")
  `LLS_ASSERT_NXT(a_decide_busy, in_valid && !in_stall && in_mode, in_stall, "decide transfer not followed by busy")
  `LLS_ASSERT_IMP(a_result_from_work, $rose(out_valid), $past(in_stall), "result without a decide in progress")
  `LLS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_burst), "stalled result dropped or changed")

endmodule

bind lowest_linger_path_select lls_checker u_lls_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .in_mode    (in_mode),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_failed (out_failed),
  .out_burst  (out_burst)
);
